>>> rtl/dsm_pkg.sv
// ============================================================================
// dsm_pkg: shared types, constants and arithmetic helpers
// Object record layout, item mode codes and the 24.8 fixed-point spring math
// used by the motion table and its spring datapath.
// ============================================================================
package dsm_pkg;

    localparam int OBJECTS = 16;
    localparam int IDX_W   = (OBJECTS > 1) ? $clog2(OBJECTS) : 1;

    localparam int INDEX_W = 4;
    localparam int PX_IN_W = 11;
    localparam int FIX_W   = 32;
    localparam int PIX_W   = 24;
    localparam int GAIN_W  = 4;

    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(1);

    localparam int FIX_SHIFT  = 8;
    localparam int DAMP_SHIFT = 8;
    localparam int PULL_SHIFT = 3;

    localparam logic [FIX_W-1:0] FIX_ONE    = FIX_W'(1) << FIX_SHIFT;
    localparam logic [FIX_W-1:0] PIX_BIAS   = FIX_ONE - FIX_W'(1);
    localparam logic [FIX_W-1:0] DAMP_NUM   = FIX_W'(179);
    localparam logic [FIX_W-1:0] DAMP_ROUND = FIX_W'(1) << (DAMP_SHIFT - 1);
    localparam logic [FIX_W-1:0] SNAP_LIMIT = FIX_ONE >> 6;
    localparam logic [FIX_W-1:0] PULL_BIAS  = (FIX_W'(1) << PULL_SHIFT) - FIX_W'(1);

    typedef enum logic [2:0] {
        MODE_TICK    = 3'd0,
        MODE_SET_POS = 3'd1,
        MODE_KICK    = 3'd2,
        MODE_SET_SR  = 3'd3,
        MODE_RESET   = 3'd4
    } dsm_mode_t;

    // One object's whole state, kept as a single memory word.
    typedef struct packed {
        logic [FIX_W-1:0] pos_x;
        logic [FIX_W-1:0] pos_y;
        logic [FIX_W-1:0] tgt_x;
        logic [FIX_W-1:0] tgt_y;
        logic [FIX_W-1:0] vel_x;
        logic [FIX_W-1:0] vel_y;
        logic [FIX_W-1:0] scl_cur;
        logic [FIX_W-1:0] scl_tgt;
        logic [FIX_W-1:0] rot_cur;
        logic [FIX_W-1:0] rot_tgt;
        logic [FIX_W-1:0] vel_scl;
        logic [FIX_W-1:0] vel_rot;
    } dsm_rec_t;

    localparam int REC_W = $bits(dsm_rec_t);

    localparam dsm_rec_t RESET_REC = '{scl_cur: FIX_ONE, scl_tgt: FIX_ONE, default: '0};

    // Signed divide by 8, truncated toward zero.
    function automatic logic [FIX_W-1:0] pull_div(input logic [FIX_W-1:0] p);
        logic [FIX_W-1:0] adj;
        adj = p + (p[FIX_W-1] ? PULL_BIAS : '0);
        return FIX_W'($signed(adj) >>> PULL_SHIFT);
    endfunction

    // Damping: (v * 179 + 128) with an arithmetic shift right by 8.
    function automatic logic [FIX_W-1:0] damp(input logic [FIX_W-1:0] v);
        logic [FIX_W-1:0] u;
        u = FIX_W'(v * DAMP_NUM) + DAMP_ROUND;
        return FIX_W'($signed(u) >>> DAMP_SHIFT);
    endfunction

    // Unsigned magnitude below the snap limit; the most negative value never is.
    function automatic logic is_small(input logic [FIX_W-1:0] v);
        logic [FIX_W-1:0] m;
        m = v[FIX_W-1] ? (FIX_W'(0) - v) : v;
        return m < SNAP_LIMIT;
    endfunction

    // Whole pixels, truncated toward zero.
    function automatic logic [PIX_W-1:0] to_pixels(input logic [FIX_W-1:0] v);
        logic [FIX_W-1:0] adj;
        adj = v + (v[FIX_W-1] ? PIX_BIAS : '0);
        return adj[FIX_SHIFT +: PIX_W];
    endfunction

endpackage

>>> rtl/damped_spring_motion_table.sv
// ============================================================================
// damped_spring_motion_table: table of objects eased by damped springs
// Each object's position, scale and rotation follow their targets through a
// fixed-point spring with damping; a tick advances one object and reports it.
// ============================================================================
// Usage:
// The input channel (s_valid/s_ready) takes one item per transfer. A tick
// advances the addressed object and returns one result on the m_ channel;
// the other modes update the object's entry and return nothing. Items whose
// index is beyond the table, or whose mode is not defined, are taken and
// dropped.
// The whole object record sits in one memory word. Every item is a
// read-modify-write of that word: the read is issued at the transfer, the
// pull step uses the read data in the next cycle, and a tick then settles and
// writes back in its settle step; other items write back in the pull step.
// Only one item is in flight, so no access can overlap another.
// The result sits in an output register, so the next item is taken while
// the receiver stalls; a following tick then holds in its settle cycle
// until the output register is free.
// Reset clears a valid bit per entry; an entry never written reads as a
// freshly reset object, so no clearing pass is needed. The gain resets to 1.
// Write it through cfg_wr_en/cfg_wr_data while the block idles; nothing enforces it.
// ============================================================================
module damped_spring_motion_table (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [dsm_pkg::GAIN_W-1:0]          cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [2:0]                          s_mode,
    input  logic [dsm_pkg::INDEX_W-1:0]         s_object_index,
    input  logic signed [dsm_pkg::PX_IN_W-1:0]  s_target_x_px,
    input  logic signed [dsm_pkg::PX_IN_W-1:0]  s_target_y_px,
    input  logic signed [dsm_pkg::FIX_W-1:0]    s_scale_value,
    input  logic signed [dsm_pkg::FIX_W-1:0]    s_rotation_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [dsm_pkg::INDEX_W-1:0]         m_out_index,
    output logic signed [dsm_pkg::PIX_W-1:0]    m_pixel_x,
    output logic signed [dsm_pkg::PIX_W-1:0]    m_pixel_y,
    output logic signed [dsm_pkg::FIX_W-1:0]    m_scale_now,
    output logic signed [dsm_pkg::FIX_W-1:0]    m_rotation_now,
    output logic signed [dsm_pkg::FIX_W-1:0]    m_tilt_angle
);
    import dsm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_PULL   = 3'b010,
        ST_SETTLE = 3'b100
    } dsm_state_t;

    dsm_state_t                state_reg;
    dsm_state_t                state_next;

    // Item captured at the input transfer.
    dsm_mode_t                 mode_reg;
    logic [INDEX_W-1:0]        idx_reg;
    logic signed [PX_IN_W-1:0] tx_reg;
    logic signed [PX_IN_W-1:0] ty_reg;
    logic [FIX_W-1:0]          sv_reg;
    logic [FIX_W-1:0]          rv_reg;

    logic [GAIN_W-1:0]         gain_reg;
    logic [OBJECTS-1:0]        valid_reg;

    logic                      m_valid_reg;
    logic [INDEX_W-1:0]        out_index_reg;
    logic [PIX_W-1:0]          pixel_x_reg;
    logic [PIX_W-1:0]          pixel_y_reg;
    logic [FIX_W-1:0]          scale_reg;
    logic [FIX_W-1:0]          rotation_reg;
    logic [FIX_W-1:0]          tilt_reg;

    logic                      in_xfer;
    logic                      in_ok;
    logic                      out_stall;
    logic                      out_load;
    logic                      spring_load;
    logic [IDX_W-1:0]          ram_addr;
    logic                      ram_we;
    logic [REC_W-1:0]          ram_wdata;
    logic [REC_W-1:0]          ram_rdata;
    dsm_rec_t                  rec_rd;
    dsm_rec_t                  rec_mod;
    dsm_rec_t                  rec_settled;

    // ------------------------------------------------------------------
    // Input side. Only items that address a real object with a defined
    // mode go on to the pull step; the rest finish at the transfer.
    // ------------------------------------------------------------------
    assign s_ready  = (state_reg == ST_IDLE);
    assign in_xfer  = s_valid && s_ready;
    assign in_ok    = (32'(s_object_index) < 32'(OBJECTS)) && (s_mode <= 3'(MODE_RESET));
    assign ram_addr = IDX_W'(idx_reg);

    assign out_stall   = m_valid_reg && !m_ready;
    assign out_load    = (state_reg == ST_SETTLE) && !out_stall;
    assign spring_load = (state_reg == ST_PULL) && (mode_reg == MODE_TICK);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_xfer && in_ok) begin
                    state_next = ST_PULL;
                end
            end
            ST_PULL: begin
                state_next = (mode_reg == MODE_TICK) ? ST_SETTLE : ST_IDLE;
            end
            ST_SETTLE: begin
                if (!out_stall) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            mode_reg <= dsm_mode_t'(s_mode);
            idx_reg  <= s_object_index;
            tx_reg   <= s_target_x_px;
            ty_reg   <= s_target_y_px;
            sv_reg   <= s_scale_value;
            rv_reg   <= s_rotation_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= GAIN_RESET;
        end else if (cfg_wr_en) begin
            gain_reg <= cfg_wr_data;
        end
    end

    // ------------------------------------------------------------------
    // Object memory. An entry that was never written since reset reads
    // as a freshly reset object.
    // ------------------------------------------------------------------
    dsm_ram #(
        .WIDTH (REC_W),
        .DEPTH (OBJECTS)
    ) u_obj_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (ram_wdata),
        .re    (in_xfer),
        .raddr (IDX_W'(s_object_index)),
        .rdata (ram_rdata)
    );

    assign rec_rd = valid_reg[ram_addr] ? dsm_rec_t'(ram_rdata) : RESET_REC;

    // Updates for the modes that only write fields of the entry.
    always_comb begin
        rec_mod = rec_rd;
        case (mode_reg)
            MODE_SET_POS: begin
                rec_mod.tgt_x = FIX_W'(tx_reg) << FIX_SHIFT;
                rec_mod.tgt_y = FIX_W'(ty_reg) << FIX_SHIFT;
            end
            MODE_KICK: begin
                rec_mod.vel_scl = sv_reg;
                rec_mod.vel_rot = rv_reg;
            end
            MODE_SET_SR: begin
                rec_mod.scl_tgt = sv_reg;
                rec_mod.rot_tgt = rv_reg;
            end
            MODE_RESET: begin
                rec_mod = RESET_REC;
            end
            default: begin
                rec_mod = rec_rd;
            end
        endcase
    end

    // An object at rest comes out of the spring update unchanged, so a
    // tick needs no separate test for it.
    dsm_spring u_spring (
        .aclk    (aclk),
        .load    (spring_load),
        .gain    (gain_reg),
        .rec_in  (rec_rd),
        .rec_out (rec_settled)
    );

    // Field writes go back in the pull cycle; a tick writes when it settles.
    always_comb begin
        ram_we    = 1'b0;
        ram_wdata = REC_W'(rec_mod);
        if ((state_reg == ST_PULL) && (mode_reg != MODE_TICK)) begin
            ram_we = 1'b1;
        end else if (out_load) begin
            ram_we    = 1'b1;
            ram_wdata = REC_W'(rec_settled);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ram_we) begin
            valid_reg[ram_addr] <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Output register. It frees itself on a transfer and is refilled only
    // by a tick's settle cycle.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_index_reg <= idx_reg;
            pixel_x_reg   <= to_pixels(rec_settled.pos_x);
            pixel_y_reg   <= to_pixels(rec_settled.pos_y);
            scale_reg     <= rec_settled.scl_cur;
            rotation_reg  <= rec_settled.rot_cur;
            tilt_reg      <= rec_settled.rot_cur - rec_settled.vel_x;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_out_index    = out_index_reg;
    assign m_pixel_x      = pixel_x_reg;
    assign m_pixel_y      = pixel_y_reg;
    assign m_scale_now    = scale_reg;
    assign m_rotation_now = rotation_reg;
    assign m_tilt_angle   = tilt_reg;

`ifndef SYNTHESIS
    // The state register keeps exactly one hot bit.
    a_state_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("state register is not one-hot");

    // A tick on a real object passes from the transfer through the pull state to its settle state.
    a_tick_path: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && in_ok && (s_mode == 3'(MODE_TICK)))
        |=> (state_reg == ST_PULL) ##1 (state_reg == ST_SETTLE))
        else $error("tick did not advance to the settle cycle");

    // The memory is never written while the block idles.
    a_we_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg != ST_IDLE))
        else $error("memory write while idle");

    // Only a tick fills the output register.
    a_out_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (mode_reg == MODE_TICK))
        else $error("result produced by an item that is not a tick");
`endif

endmodule

>>> rtl/dsm_ram.sv
// ============================================================================
// dsm_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ============================================================================
module dsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/dsm_spring.sv
// ============================================================================
// dsm_spring: two-step spring update of one object record
// The first step adds the spring pull to every velocity and registers the
// record; the second step snaps or damps and integrates.
// ============================================================================
module dsm_spring (
    input  logic                          aclk,
    input  logic                          load,
    input  logic [dsm_pkg::GAIN_W-1:0]    gain,
    input  dsm_pkg::dsm_rec_t             rec_in,
    output dsm_pkg::dsm_rec_t             rec_out
);
    import dsm_pkg::*;

    dsm_rec_t         pulled_reg;
    dsm_rec_t         pulled_next;
    logic [FIX_W-1:0] prod_x;
    logic [FIX_W-1:0] prod_y;
    logic             snap_xy;
    logic             snap_scl;
    logic             snap_rot;
    logic [FIX_W-1:0] damp_x;
    logic [FIX_W-1:0] damp_y;
    logic [FIX_W-1:0] damp_scl;
    logic [FIX_W-1:0] damp_rot;

    // Pull step: the position pull is scaled by the gain, scale and rotation are not.
    always_comb begin
        prod_x      = FIX_W'((rec_in.tgt_x - rec_in.pos_x) * FIX_W'(gain));
        prod_y      = FIX_W'((rec_in.tgt_y - rec_in.pos_y) * FIX_W'(gain));
        pulled_next = rec_in;
        pulled_next.vel_x   = rec_in.vel_x + pull_div(prod_x);
        pulled_next.vel_y   = rec_in.vel_y + pull_div(prod_y);
        pulled_next.vel_scl = rec_in.vel_scl + pull_div(rec_in.scl_tgt - rec_in.scl_cur);
        pulled_next.vel_rot = rec_in.vel_rot + pull_div(rec_in.rot_tgt - rec_in.rot_cur);
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            pulled_reg <= pulled_next;
        end
    end

    // Settle step: x and y snap together, scale and rotation each on their own.
    always_comb begin
        snap_xy  = is_small(pulled_reg.vel_x) && is_small(pulled_reg.vel_y);
        snap_scl = is_small(pulled_reg.vel_scl);
        snap_rot = is_small(pulled_reg.vel_rot);
        damp_x   = damp(pulled_reg.vel_x);
        damp_y   = damp(pulled_reg.vel_y);
        damp_scl = damp(pulled_reg.vel_scl);
        damp_rot = damp(pulled_reg.vel_rot);
        rec_out  = pulled_reg;
        if (snap_xy) begin
            rec_out.vel_x = '0;
            rec_out.vel_y = '0;
            rec_out.pos_x = pulled_reg.tgt_x;
            rec_out.pos_y = pulled_reg.tgt_y;
        end else begin
            rec_out.vel_x = damp_x;
            rec_out.vel_y = damp_y;
            rec_out.pos_x = pulled_reg.pos_x + damp_x;
            rec_out.pos_y = pulled_reg.pos_y + damp_y;
        end
        if (snap_scl) begin
            rec_out.vel_scl = '0;
            rec_out.scl_cur = pulled_reg.scl_tgt;
        end else begin
            rec_out.vel_scl = damp_scl;
            rec_out.scl_cur = pulled_reg.scl_cur + damp_scl;
        end
        if (snap_rot) begin
            rec_out.vel_rot = '0;
            rec_out.rot_cur = pulled_reg.rot_tgt;
        end else begin
            rec_out.vel_rot = damp_rot;
            rec_out.rot_cur = pulled_reg.rot_cur + damp_rot;
        end
    end

endmodule
